@@ rtl/core/efr_pkg.sv @@
`timescale 1ns / 1ps

package efr_pkg;

  localparam int MAX_FRAME_DEF = 32;
  localparam int NUM_SLOTS_DEF = 4;

  localparam logic [7:0] HEAD_BYTE = 8'hFD;
  localparam logic [7:0] ESC_BYTE  = 8'hFE;
  localparam logic [7:0] TAIL_BYTE = 8'hF8;
  localparam logic [7:0] ESC_HEAD  = 8'h7D;
  localparam logic [7:0] ESC_TAIL  = 8'h78;
  localparam logic [7:0] ESC_ESC   = 8'h7E;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOMATCH  = 2'd1;
  localparam logic [1:0] ST_CSUM     = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SLOT0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CSUM_EN = 3'd4;

  localparam int POS_W      = 5;
  localparam int LAST_POS_W = 6;

  typedef struct packed {
    logic                  is_frame;
    logic [1:0]            status;
    logic [1:0]            slot;
    logic [LAST_POS_W-1:0] last_pos;
  } cmd_t;

  typedef struct packed {
    logic                  en;
    logic [LAST_POS_W-1:0] addr;
    logic [7:0]            data;
  } mem_wr_t;

  typedef struct packed {
    logic [7:0]       frame_byte;
    logic [POS_W-1:0] byte_pos;
    logic [1:0]       slot;
    logic [1:0]       status;
    logic             last;
  } result_t;

endpackage

@@ rtl/core/efr_front.sv @@
`timescale 1ns / 1ps

module efr_front import efr_pkg::*; #(
  parameter int MAX_FRAME = MAX_FRAME_DEF,
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  push,
  input  logic [7:0]            rx_byte,
  output logic                  full,
  input  logic                  q_full,
  input  logic                  frame_done,
  output logic                  cmd_push,
  output cmd_t                  cmd,
  output mem_wr_t               mem_wr
);

  localparam int FILL_W = $clog2(MAX_FRAME + 1);

  logic [CFG_DATA_W-1:0] slot_cfg [NUM_SLOTS];
  logic                  csum_en;

  logic              in_frame, in_frame_next;
  logic              escape_pending, escape_pending_next;
  logic [FILL_W-1:0] fill_count, fill_count_next;
  logic [7:0]        sum_prev, sum_prev_next;
  logic [7:0]        last_byte, last_byte_next;
  logic [7:0]        type_byte, type_byte_next;
  logic              busy;

  logic accept;

  assign full   = q_full | busy;
  assign accept = push & ~full;

  always_comb begin
    logic              is_head;
    logic              in_eff;
    logic              esc_eff;
    logic [FILL_W-1:0] fill_eff;
    logic [7:0]        v;
    logic              store;
    logic              tail;
    logic [7:0]        type_eff;
    logic [7:0]        n;
    logic              found;
    logic [1:0]        mslot;

    in_frame_next       = in_frame;
    escape_pending_next = escape_pending;
    fill_count_next     = fill_count;
    sum_prev_next       = sum_prev;
    last_byte_next      = last_byte;
    type_byte_next      = type_byte;
    cmd_push            = 1'b0;
    cmd                 = '0;
    mem_wr              = '0;

    is_head  = (rx_byte == HEAD_BYTE);
    in_eff   = in_frame | is_head;
    esc_eff  = escape_pending & ~is_head;
    fill_eff = is_head ? '0 : fill_count;
    v        = rx_byte;
    store    = 1'b0;
    tail     = 1'b0;
    found    = 1'b0;
    mslot    = '0;

    if (accept && in_eff) begin
      in_frame_next       = 1'b1;
      escape_pending_next = 1'b0;
      fill_count_next     = fill_eff;
      if (esc_eff) begin
        unique case (rx_byte)
          ESC_HEAD: v = HEAD_BYTE;
          ESC_TAIL: v = TAIL_BYTE;
          ESC_ESC:  v = ESC_BYTE;
          default:  v = rx_byte;
        endcase
        store = 1'b1;
      end else if (rx_byte == ESC_BYTE) begin
        escape_pending_next = 1'b1;
      end else begin
        store = 1'b1;
        tail  = (rx_byte == TAIL_BYTE);
      end
    end

    type_eff = (fill_eff == FILL_W'(1)) ? v : type_byte;
    n        = 8'(fill_eff) + 8'd1;
    for (int s = 0; s < NUM_SLOTS; s++) begin
      if (type_eff == slot_cfg[s][7:0] && n == slot_cfg[s][15:8]) begin
        found = 1'b1;
        mslot = 2'(s);
      end
    end

    if (store) begin
      if (fill_eff >= FILL_W'(MAX_FRAME)) begin
        in_frame_next       = 1'b0;
        escape_pending_next = 1'b0;
        fill_count_next     = '0;
        cmd_push            = 1'b1;
        cmd.status          = ST_OVERFLOW;
      end else begin
        mem_wr.en       = 1'b1;
        mem_wr.addr     = LAST_POS_W'(fill_eff);
        mem_wr.data     = v;
        fill_count_next = FILL_W'(fill_eff + 1'b1);
        last_byte_next  = v;
        if (fill_eff <= FILL_W'(1)) begin
          sum_prev_next = '0;
        end else begin
          sum_prev_next = 8'(sum_prev + last_byte);
        end
        if (fill_eff == FILL_W'(1)) begin
          type_byte_next = v;
        end
        if (tail) begin
          in_frame_next       = 1'b0;
          escape_pending_next = 1'b0;
          fill_count_next     = '0;
          cmd_push            = 1'b1;
          if (csum_en && sum_prev != last_byte) begin
            cmd.status = ST_CSUM;
          end else if (found) begin
            cmd.is_frame = 1'b1;
            cmd.status   = ST_OK;
            cmd.slot     = mslot;
            cmd.last_pos = LAST_POS_W'(fill_eff);
          end else begin
            cmd.status = ST_NOMATCH;
          end
        end
      end
    end
  end

  for (genvar s = 0; s < NUM_SLOTS; s++) begin : g_slot
    always_ff @(posedge clk) begin
      if (rst) begin
        slot_cfg[s] <= '0;
      end else if (cfg_write && cfg_index == REG_SLOT0 + CFG_IDX_W'(s)) begin
        slot_cfg[s] <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      csum_en        <= 1'b0;
      in_frame       <= 1'b0;
      escape_pending <= 1'b0;
      fill_count     <= '0;
      busy           <= 1'b0;
    end else begin
      if (cfg_write && cfg_index == REG_CSUM_EN) begin
        csum_en <= cfg_data[0];
      end
      in_frame       <= in_frame_next;
      escape_pending <= escape_pending_next;
      fill_count     <= fill_count_next;
      if (cmd_push && cmd.is_frame) begin
        busy <= 1'b1;
      end else if (frame_done) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    sum_prev  <= sum_prev_next;
    last_byte <= last_byte_next;
    type_byte <= type_byte_next;
  end

endmodule

@@ rtl/core/efr_cmdq.sv @@
`timescale 1ns / 1ps

module efr_cmdq import efr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic valid,
  output logic full,
  output cmd_t head
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);

  cmd_t             entry [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [PTR_W:0]   count;
  logic             do_push, do_pop;

  assign valid   = (count != '0);
  assign full    = (count == (PTR_W + 1)'(DEPTH));
  assign head    = entry[rd_ptr];
  assign do_push = push & ~full;
  assign do_pop  = pop & valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (PTR_W + 1)'(do_push) - (PTR_W + 1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

endmodule

@@ rtl/core/efr_back.sv @@
`timescale 1ns / 1ps

module efr_back import efr_pkg::*; #(
  parameter int MAX_FRAME = MAX_FRAME_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  mem_wr_t mem_wr,
  input  logic    cmd_valid,
  input  cmd_t    cmd,
  output logic    cmd_pop,
  output logic    frame_done,
  output logic    empty,
  input  logic    pop,
  output result_t res
);

  localparam int AW = $clog2(MAX_FRAME);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EMIT = 1'b1;

  logic [7:0] mem [MAX_FRAME];

  logic          state, state_next;
  logic [AW-1:0] idx, idx_next;
  logic [AW-1:0] last_idx, last_idx_next;
  logic [1:0]    cur_slot, cur_slot_next;

  logic          rd_en;
  logic          rd_pend;
  logic [7:0]    rd_data;
  logic [AW-1:0] rd_pos;
  logic [1:0]    rd_slot;
  logic          rd_last;

  result_t    fifo [2];
  logic       wp, rp;
  logic [1:0] cnt;
  logic       room;
  logic       rej_wr;
  logic       fifo_wr;
  logic       fifo_rd;
  result_t    wdata;

  assign room    = (cnt == 2'd0) || (cnt == 2'd1 && !rd_pend);
  assign empty   = (cnt == 2'd0);
  assign res     = fifo[rp];
  assign fifo_rd = pop & ~empty;
  assign fifo_wr = rd_pend | rej_wr;

  always_comb begin
    state_next    = state;
    idx_next      = idx;
    last_idx_next = last_idx;
    cur_slot_next = cur_slot;
    cmd_pop       = 1'b0;
    frame_done    = 1'b0;
    rd_en         = 1'b0;
    rej_wr        = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          if (cmd.is_frame) begin
            cmd_pop       = 1'b1;
            state_next    = S_EMIT;
            idx_next      = '0;
            last_idx_next = AW'(cmd.last_pos);
            cur_slot_next = cmd.slot;
          end else if (room && !rd_pend) begin
            cmd_pop = 1'b1;
            rej_wr  = 1'b1;
          end
        end
      end
      S_EMIT: begin
        if (room) begin
          rd_en = 1'b1;
          if (idx == last_idx) begin
            state_next = S_IDLE;
            frame_done = 1'b1;
          end else begin
            idx_next = idx + 1'b1;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    wdata = '0;
    if (rd_pend) begin
      wdata.frame_byte = rd_data;
      wdata.byte_pos   = POS_W'(rd_pos);
      wdata.slot       = rd_slot;
      wdata.status     = ST_OK;
      wdata.last       = rd_last;
    end else begin
      wdata.status = cmd.status;
      wdata.last   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_wr.en) begin
      mem[AW'(mem_wr.addr)] <= mem_wr.data;
    end
    if (rd_en) begin
      rd_data <= mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      rd_pend <= 1'b0;
      wp      <= 1'b0;
      rp      <= 1'b0;
      cnt     <= 2'd0;
    end else begin
      state   <= state_next;
      rd_pend <= rd_en;
      if (fifo_wr) begin
        wp <= ~wp;
      end
      if (fifo_rd) begin
        rp <= ~rp;
      end
      cnt <= cnt + 2'(fifo_wr) - 2'(fifo_rd);
    end
  end

  always_ff @(posedge clk) begin
    idx      <= idx_next;
    last_idx <= last_idx_next;
    cur_slot <= cur_slot_next;
    if (rd_en) begin
      rd_pos  <= idx;
      rd_slot <= cur_slot;
      rd_last <= (idx == last_idx);
    end
    if (fifo_wr) begin
      fifo[wp] <= wdata;
    end
  end

endmodule

@@ rtl/core/escaped_frame_receiver_unit.sv @@
// a frame closed by its tail passes the command queue, the back end's emit state, the buffer
// read register and the result queue before its first result shows; a reject result passes
// the command queue and the result queue. Input: one byte per cycle while full is low; a
// stored frame is read out byte by byte through the single read port of the frame buffer,
// held back when the two-entry result queue has no room; after the tail of a matching frame,
// full stays high until the last buffer read; rst clears state, slots and queues

`timescale 1ns / 1ps

module escaped_frame_receiver_unit import efr_pkg::*; #(
  parameter int MAX_FRAME = MAX_FRAME_DEF,
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  push,
  output logic                  full,
  input  logic [7:0]            rx_byte,
  output logic                  empty,
  input  logic                  pop,
  output logic [7:0]            frame_byte,
  output logic [POS_W-1:0]      byte_pos,
  output logic [1:0]            slot,
  output logic [1:0]            status,
  output logic                  last
);

  logic    q_full;
  logic    frame_done;
  logic    cmd_push;
  cmd_t    cmd_in;
  mem_wr_t mem_wr;
  logic    cmd_valid;
  logic    cmd_pop;
  cmd_t    cmd_head;
  result_t res;

  efr_front #(
    .MAX_FRAME(MAX_FRAME),
    .NUM_SLOTS(NUM_SLOTS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push       (push),
    .rx_byte    (rx_byte),
    .full       (full),
    .q_full     (q_full),
    .frame_done (frame_done),
    .cmd_push   (cmd_push),
    .cmd        (cmd_in),
    .mem_wr     (mem_wr)
  );

  efr_cmdq u_cmdq (
    .clk      (clk),
    .rst      (rst),
    .push     (cmd_push),
    .push_cmd (cmd_in),
    .pop      (cmd_pop),
    .valid    (cmd_valid),
    .full     (q_full),
    .head     (cmd_head)
  );

  efr_back #(
    .MAX_FRAME(MAX_FRAME)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .mem_wr     (mem_wr),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd_head),
    .cmd_pop    (cmd_pop),
    .frame_done (frame_done),
    .empty      (empty),
    .pop        (pop),
    .res        (res)
  );

  assign frame_byte = res.frame_byte;
  assign byte_pos   = res.byte_pos;
  assign slot       = res.slot;
  assign status     = res.status;
  assign last       = res.last;

endmodule

@@ rtl/core/efr_checker.sv @@
`timescale 1ns / 1ps

module efr_checker import efr_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             full,
  input logic             empty,
  input logic             pop,
  input logic [7:0]       frame_byte,
  input logic [POS_W-1:0] byte_pos,
  input logic [1:0]       slot,
  input logic [1:0]       status,
  input logic             last
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(frame_byte) && $stable(byte_pos) &&
                          $stable(slot) && $stable(status) && $stable(last)))
    else $error("waiting result changed before pop");

  a_reject: assert property (@(posedge clk) disable iff (rst)
    (!empty && status != ST_OK) |->
      (last && frame_byte == 8'h00 && byte_pos == '0 && slot == '0))
    else $error("reject result malformed");

  a_tail: assert property (@(posedge clk) disable iff (rst)
    (!empty && status == ST_OK && last) |-> (frame_byte == TAIL_BYTE))
    else $error("final frame byte is not the tail");

  a_reset: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("queues not empty after reset");

endmodule

bind escaped_frame_receiver_unit efr_checker u_efr_checker (.*);
